/* hw/rtl/ipbl_pkg.sv */
`timescale 1ns / 1ps

package ipbl_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int ADDR_W          = 32;
  localparam int CMD_W           = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CHECK_IN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK_OUT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_IN    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_OUT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADD_BOTH  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] ip_address;
  } ipbl_req_t;

  typedef struct packed {
    logic drop;
    logic list_full;
  } ipbl_rsp_t;

endpackage

/* hw/rtl/ipbl_ram.sv */
`timescale 1ns / 1ps

// simple dual port RAM, one write, one registered read
module ipbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/ip_blocklist_filter.sv */
`timescale 1ns / 1ps

// Channel   Ports                 Handshake
// -------   -------------------   -----------------------------------------
// command   req (cmd, ip_address) beat taken on the edge with start && !busy
// result    rsp (drop, list_full) beat shown for one cycle while done is high
//
// Add, clear and unused codes: result in the cycle after the beat, busy stays low.
// Check: one comparator walks the selected list, one RAM read a cycle; result
//   once the whole list is walked, sooner on a hit, and in the cycle after the
//   beat for an empty list. busy is high during the walk.
// Reset (rst, synchronous) empties both counts; RAM contents are not cleared.
// The receiver cannot stall: each result is valid for its single done cycle.
module ip_blocklist_filter
  import ipbl_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ipbl_req_t req,
  output logic      done,
  output ipbl_rsp_t rsp
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t            state;
  logic [CNT_W-1:0]  in_cnt;
  logic [CNT_W-1:0]  out_cnt;
  logic [CNT_W-1:0]  scan_idx;   // next address to read
  logic [CNT_W-1:0]  scan_cnt;   // length of list being walked
  logic              scan_out;   // walking the outgoing list
  logic              pend;       // rd_data holds entry scan_idx-1
  logic [ADDR_W-1:0] key;

  logic              accept;
  logic              in_full;
  logic              out_full;
  logic              add_in;
  logic              add_out;
  logic              we_in;
  logic              we_out;
  logic [ADDR_W-1:0] rd_in;
  logic [ADDR_W-1:0] rd_out;
  logic [ADDR_W-1:0] rd_sel;
  logic              hit;
  logic              last;

  assign accept   = start && !busy;
  assign in_full  = (in_cnt == CNT_MAX);
  assign out_full = (out_cnt == CNT_MAX);
  assign add_in   = (req.cmd == CMD_ADD_IN)  || (req.cmd == CMD_ADD_BOTH);
  assign add_out  = (req.cmd == CMD_ADD_OUT) || (req.cmd == CMD_ADD_BOTH);
  assign we_in    = accept && add_in  && !in_full;
  assign we_out   = accept && add_out && !out_full;

  // the one shared comparator
  assign rd_sel = scan_out ? rd_out : rd_in;
  assign hit    = pend && (rd_sel == key);
  assign last   = pend && (scan_idx == scan_cnt);

  ipbl_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_in_ram (
    .clk     (clk),
    .we      (we_in),
    .wr_addr (in_cnt[IDX_W-1:0]),
    .wr_data (req.ip_address),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_in)
  );

  ipbl_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_out_ram (
    .clk     (clk),
    .we      (we_out),
    .wr_addr (out_cnt[IDX_W-1:0]),
    .wr_data (req.ip_address),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      in_cnt  <= '0;
      out_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            key      <= req.ip_address;
            scan_idx <= '0;
            pend     <= 1'b0;
            unique case (req.cmd)
              CMD_CHECK_IN, CMD_CHECK_OUT: begin
                rsp      <= '0;
                scan_out <= (req.cmd == CMD_CHECK_OUT);
                scan_cnt <= (req.cmd == CMD_CHECK_OUT) ? out_cnt : in_cnt;
                if (((req.cmd == CMD_CHECK_OUT) ? out_cnt : in_cnt) == '0) begin
                  done <= 1'b1;          // empty list: accept at once
                end else begin
                  done  <= 1'b0;
                  state <= SCAN;
                  busy  <= 1'b1;
                end
              end
              CMD_ADD_IN, CMD_ADD_OUT, CMD_ADD_BOTH: begin
                if (we_in) begin
                  in_cnt <= in_cnt + CNT_W'(1);
                end
                if (we_out) begin
                  out_cnt <= out_cnt + CNT_W'(1);
                end
                // {drop, list_full}
                rsp  <= {1'b0, (add_in && in_full) || (add_out && out_full)};
                done <= 1'b1;
              end
              CMD_CLEAR: begin
                in_cnt  <= '0;
                out_cnt <= '0;
                rsp     <= '0;
                done    <= 1'b1;
              end
              default: begin
                rsp  <= '0;
                done <= 1'b1;            // unused code: no change
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        SCAN: begin
          scan_idx <= scan_idx + CNT_W'(1);
          pend     <= 1'b1;
          if (hit || last) begin
            rsp   <= {hit, 1'b0};        // {drop, list_full}
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= IDLE;
          end else begin
            done <= 1'b0;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/ipbl_checker.sv */
`timescale 1ns / 1ps

module ipbl_checker
  import ipbl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input ipbl_req_t req,
  input logic      done,
  input ipbl_rsp_t rsp
);

  // non-check commands answer on the next cycle without going busy
  a_quick_rsp: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.cmd != CMD_CHECK_IN && req.cmd != CMD_CHECK_OUT
    |=> done && !busy)
    else $error("add/clear beat not answered next cycle");

  // a check either starts a walk or answers at once
  a_check_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.cmd == CMD_CHECK_IN || req.cmd == CMD_CHECK_OUT)
    |=> busy || done)
    else $error("check beat neither walking nor answered");

  // the end of a walk is always marked by a result
  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("walk ended without result");

  // a drop only comes out of a walk, and never with list_full
  a_drop_src: assert property (@(posedge clk) disable iff (rst)
    done && rsp.drop |-> $past(busy) && !rsp.list_full)
    else $error("drop without list walk");

endmodule

bind ip_blocklist_filter ipbl_checker u_ipbl_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

/* tb/sv/tb_ip_blocklist_filter.sv */
`timescale 1ns / 1ps

module tb_ip_blocklist_filter;
  import ipbl_pkg::*;

  localparam int LIST_DEPTH  = MAX_ENTRIES_DEF;
  // Longest run of cycles with neither a command beat nor a result: a full walk
  // plus the longest driver gap, taken many times over.
  localparam int STALL_LIMIT = 2000;
  localparam int N_RANDOM    = 1430;

  // Codes the block must treat as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    ipbl_req_t   beat;
    int unsigned gap;   // idle cycles before the beat is offered
  } cmd_item_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  ipbl_req_t req   = '0;
  logic      busy;
  logic      done;
  ipbl_rsp_t rsp;

  ip_blocklist_filter u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus store and generator helpers
  // ---------------------------------------------------------------------------
  cmd_item_t         pending_cmds[$];
  logic [ADDR_W-1:0] addr_pool[$];   // recently added addresses, source of hits
  bit                no_idle = 1'b0; // burst mode: back-to-back beats
  int unsigned       cmds_total = 0;

  function automatic void queue_cmd(logic [CMD_W-1:0] code, logic [ADDR_W-1:0] addr);
    cmd_item_t it;
    it.beat.cmd        = code;
    it.beat.ip_address = addr;
    it.gap             = no_idle ? 0 : $urandom_range(0, 19);
    pending_cmds.push_back(it);
    if (code == CMD_ADD_IN || code == CMD_ADD_OUT || code == CMD_ADD_BOTH) begin
      addr_pool.push_back(addr);
      if (addr_pool.size() > 256) void'(addr_pool.pop_front());
    end
  endfunction

  // Address for a check: mostly known entries (hits anywhere along the walk),
  // some one-bit-off near misses, the all-zero/all-one corners, and noise.
  function automatic logic [ADDR_W-1:0] probe_addr();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 9);
    if (addr_pool.size() != 0 && r <= 6) begin
      k = $urandom_range(0, addr_pool.size() - 1);
      if (r == 6) return addr_pool[k] ^ (32'd1 << $urandom_range(0, ADDR_W - 1));
      return addr_pool[k];
    end
    if (r == 7) return $urandom_range(0, 1) ? '1 : '0;
    return $urandom;
  endfunction

  // Address for an add: fresh values, with duplicates and corners mixed in.
  function automatic logic [ADDR_W-1:0] entry_addr();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (addr_pool.size() != 0 && r < 5) return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    if (r == 5) return '0;
    if (r == 6) return '1;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Blocklist predictor: own copy of both tables and their fill counts
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] in_tbl  [LIST_DEPTH];
  logic [ADDR_W-1:0] out_tbl [LIST_DEPTH];
  int unsigned       in_cnt  = 0;
  int unsigned       out_cnt = 0;

  function automatic bit listed(bit outgoing, logic [ADDR_W-1:0] addr);
    int unsigned n;
    n = outgoing ? out_cnt : in_cnt;
    for (int unsigned i = 0; i < n; i++) begin
      if ((outgoing ? out_tbl[i] : in_tbl[i]) == addr) return 1'b1;
    end
    return 1'b0;
  endfunction

  // returns 1 when the table is full and the address is refused
  function automatic bit store(bit outgoing, logic [ADDR_W-1:0] addr);
    if (outgoing) begin
      if (out_cnt >= LIST_DEPTH) return 1'b1;
      out_tbl[out_cnt] = addr;
      out_cnt++;
    end else begin
      if (in_cnt >= LIST_DEPTH) return 1'b1;
      in_tbl[in_cnt] = addr;
      in_cnt++;
    end
    return 1'b0;
  endfunction

  function automatic ipbl_rsp_t blocklist_verdict(ipbl_req_t c);
    ipbl_rsp_t v;
    bit        refused_in;
    bit        refused_out;
    v = '0;
    case (c.cmd)
      CMD_CHECK_IN:  v.drop      = listed(1'b0, c.ip_address);
      CMD_CHECK_OUT: v.drop      = listed(1'b1, c.ip_address);
      CMD_ADD_IN:    v.list_full = store(1'b0, c.ip_address);
      CMD_ADD_OUT:   v.list_full = store(1'b1, c.ip_address);
      CMD_ADD_BOTH: begin
        // both tables are tried; a full one does not stop the other
        refused_in  = store(1'b0, c.ip_address);
        refused_out = store(1'b1, c.ip_address);
        v.list_full = refused_in | refused_out;
      end
      CMD_CLEAR: begin
        // stored words stay, only the counts drop
        in_cnt  = 0;
        out_cnt = 0;
      end
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes on the falling edge, one beat per queue entry
  // ---------------------------------------------------------------------------
  bit          beat_seen = 1'b0; // set by the monitor when start && !busy was sampled
  bit          offering  = 1'b0;
  int unsigned gap_left  = 0;
  bit          gap_armed = 1'b0;

  always @(negedge clk) begin : drv
    cmd_item_t it;
    if (!rst) begin
      if (offering && beat_seen) offering = 1'b0;
      beat_seen = 1'b0;
      if (!offering && pending_cmds.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = pending_cmds[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          it        = pending_cmds.pop_front();
          req      <= it.beat;
          offering  = 1'b1;
          gap_armed = 1'b0;
        end
      end
      // start written once per step, so a held start never glitches low
      start <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor, checker and watchdog: everything sampled on the rising edge
  // ---------------------------------------------------------------------------
  ipbl_rsp_t   verdict_q[$];
  int unsigned beats_taken = 0;
  int unsigned err_cnt     = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin : mon
    ipbl_rsp_t want;
    bit        moved;
    if (!rst) begin
      moved = 1'b0;
      // the oldest expectation belongs to this result; a beat in the same
      // cycle can never be the one answered here
      if (done) begin
        moved = 1'b1;
        if (verdict_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result drop=%b list_full=%b", $time, rsp.drop,
                   rsp.list_full);
        end else begin
          want = verdict_q.pop_front();
          if (rsp.drop !== want.drop) begin
            err_cnt++;
            $display("%0t: drop mismatch, expected %b actual %b", $time, want.drop,
                     rsp.drop);
          end
          if (rsp.list_full !== want.list_full) begin
            err_cnt++;
            $display("%0t: list_full mismatch, expected %b actual %b", $time,
                     want.list_full, rsp.list_full);
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        verdict_q.push_back(blocklist_verdict(req));
        beats_taken++;
        beat_seen = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the command list, release reset, wait for the drain
  // ---------------------------------------------------------------------------
  initial begin : seq
    int unsigned seg_left;
    int unsigned r;

    // Directed: empty tables, corner addresses, hits at the head and further
    // down, duplicates, the spare codes, and a clear that keeps stale words.
    queue_cmd(CMD_CHECK_IN,  32'h0000_0000);   // empty table, accept
    queue_cmd(CMD_CHECK_OUT, 32'hFFFF_FFFF);
    queue_cmd(CMD_ADD_IN,    32'h0000_0000);
    queue_cmd(CMD_ADD_OUT,   32'hFFFF_FFFF);
    queue_cmd(CMD_CHECK_IN,  32'h0000_0000);   // hit on first entry
    queue_cmd(CMD_CHECK_OUT, 32'h0000_0000);   // wrong table, accept
    queue_cmd(CMD_CHECK_OUT, 32'hFFFF_FFFF);
    queue_cmd(CMD_CHECK_IN,  32'hFFFF_FFFF);
    queue_cmd(CMD_ADD_BOTH,  32'hA5A5_5A5A);
    queue_cmd(CMD_ADD_IN,    32'h0000_0000);   // duplicate takes another slot
    queue_cmd(CMD_CHECK_IN,  32'hA5A5_5A5A);
    queue_cmd(CMD_CHECK_OUT, 32'h5A5A_A5A5);
    queue_cmd(CMD_CHECK_OUT, 32'hA5A5_5A5A);
    queue_cmd(CMD_SPARE_6,   32'h8000_0001);
    queue_cmd(CMD_SPARE_7,   32'h7FFF_FFFE);
    queue_cmd(CMD_CHECK_IN,  32'h8000_0001);   // spare code stored nothing
    queue_cmd(CMD_CLEAR,     32'h0000_0000);
    queue_cmd(CMD_CHECK_IN,  32'h0000_0000);   // stale word must not match
    queue_cmd(CMD_CHECK_OUT, 32'hA5A5_5A5A);
    queue_cmd(CMD_ADD_IN,    32'h1234_5678);
    queue_cmd(CMD_CHECK_IN,  32'h1234_5678);

    // Random: segments of varying length, some opened by a clear, so that the
    // tables often run up to full and add-both meets one full table. Some
    // segments run with no idle cycles at all.
    seg_left = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 400);
        no_idle  = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) != 0) queue_cmd(CMD_CLEAR, $urandom);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 199) == 0) queue_cmd(CMD_CLEAR, $urandom);
      else if (r < 22) queue_cmd(CMD_CHECK_IN, probe_addr());
      else if (r < 44) queue_cmd(CMD_CHECK_OUT, probe_addr());
      else if (r < 60) queue_cmd(CMD_ADD_IN, entry_addr());
      else if (r < 76) queue_cmd(CMD_ADD_OUT, entry_addr());
      else if (r < 94) queue_cmd(CMD_ADD_BOTH, entry_addr());
      else if (r < 97) queue_cmd(CMD_SPARE_6, $urandom);
      else queue_cmd(CMD_SPARE_7, $urandom);
    end
    cmds_total = pending_cmds.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_taken < cmds_total) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    // a full walk's worth of cycles to catch any stray result
    repeat (LIST_DEPTH + 4) @(posedge clk);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
